// ===== rtl/ekdk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ekdk_pkg - shared types and constants for the departure keeper
// Operation codes, configuration register indexes, reset values and the
// stored entry layout.
// ----------------------------------------------------------------------------
package ekdk_pkg;

	localparam int KEEP_COUNT_DEF = 8;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_INSERT = 2'd1,
		OP_READ   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	localparam logic [CFG_IDX_W-1:0] CFG_CORR_EN     = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CORR_AGENCY = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WEEK_SHIFT  = 8'd3;

	localparam logic        RST_CORR_EN     = 1'b1;
	localparam logic [7:0]  RST_CORR_AGENCY = 8'd0;
	localparam logic [31:0] RST_LOOKAHEAD   = 32'd432000;
	localparam logic [31:0] RST_WEEK_SHIFT  = 32'd604800;

	typedef struct packed {
		logic signed [15:0] delay;
		logic               live;
		logic [7:0]         agency;
		logic [7:0]         heading;
		logic [7:0]         route;
	} payload_t;

	typedef struct packed {
		logic [31:0] tstamp;
		payload_t    pl;
	} entry_t;

endpackage

// ===== rtl/ekdk_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ekdk_ifs - channel interfaces of the departure keeper
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface ekdk_in_if import ekdk_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic [31:0]        dep_time;
	logic [31:0]        now_time;
	logic [7:0]         route_ref;
	logic [7:0]         heading;
	logic [7:0]         agency_code;
	logic               live_flag;
	logic signed [15:0] delay_secs;
	logic               usable;

	modport source (
		output valid, op, dep_time, now_time, route_ref, heading, agency_code,
			live_flag, delay_secs, usable,
		input ready
	);
	modport sink (
		input valid, op, dep_time, now_time, route_ref, heading, agency_code,
			live_flag, delay_secs, usable,
		output ready
	);
endinterface

interface ekdk_out_if import ekdk_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [31:0]        out_time;
	logic [7:0]         out_route;
	logic [7:0]         out_heading;
	logic [7:0]         out_agency;
	logic               out_live;
	logic signed [15:0] out_delay;
	logic               entry_present;
	logic               last_entry;

	modport source (
		output valid, out_time, out_route, out_heading, out_agency, out_live,
			out_delay, entry_present, last_entry,
		input ready
	);
	modport sink (
		input valid, out_time, out_route, out_heading, out_agency, out_live,
			out_delay, entry_present, last_entry,
		output ready
	);
endinterface

interface ekdk_cfg_if import ekdk_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/earliest_k_departure_keeper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// earliest_k_departure_keeper - sorted list of the K earliest departures
// Keeps departures in time order in a small slot memory, with
// optional week-wrap correction on insert and an ordered read-out.
// ----------------------------------------------------------------------------
// One item is handled at a time; dep_in.ready is high only when the block is
// idle. A clear empties the list when accepted. An insert is accepted, its
// time is corrected, and then each slot visited gets a registered read and
// then a compare and move, walking from the tail of the list toward the head
// through the one read and one write port of the slot memory; the walk is
// shorter when the new time lands near the tail. A read-out is accepted and
// then each listed entry passes the address, data and output states, the
// last held while the sink holds ready low; an empty list gives one result
// with entry_present low. Entries with equal times keep their arrival order.
// No clearing pass is needed after reset.
module earliest_k_departure_keeper import ekdk_pkg::*; #(
	parameter int KEEP_COUNT = KEEP_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ekdk_in_if.sink    dep_in,
	ekdk_out_if.source dep_out,
	ekdk_cfg_if.sink   cfg
);

	localparam int CNT_W = $clog2(KEEP_COUNT + 1);
	localparam int IDX_W = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
	localparam logic [CNT_W-1:0] FULL = CNT_W'(KEEP_COUNT);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_CORR    = 7'b0000010,
		S_INS_RD  = 7'b0000100,
		S_INS_CMP = 7'b0001000,
		S_RD_ADDR = 7'b0010000,
		S_RD_DATA = 7'b0100000,
		S_OUT     = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// configuration
	logic        corr_en_q;
	logic [7:0]  corr_agency_q;
	logic [31:0] lookahead_q;
	logic [31:0] week_shift_q;

	// working item
	logic [31:0] t_q;
	logic [31:0] now_q;
	payload_t    pl_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] rd_k_q;

	// result register
	entry_t out_ent_q;
	logic   out_present_q;
	logic   out_last_q;

	// slot memory
	entry_t mem_q [KEEP_COUNT];
	entry_t rdata_q;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t           mem_wdata;
	logic [IDX_W-1:0] mem_raddr;

	logic in_xfer, out_xfer, cfg_xfer;
	logic [CNT_W-1:0] pos_m1;
	logic [CNT_W-1:0] rd_k_p1;
	logic signed [32:0] diff;
	logic               corr_hit;

	assign in_xfer  = dep_in.valid && dep_in.ready;
	assign out_xfer = dep_out.valid && dep_out.ready;
	assign cfg_xfer = cfg.valid && cfg.ready;

	assign dep_in.ready = (state_q == S_IDLE);
	assign cfg.ready    = 1'b1;

	assign dep_out.valid         = (state_q == S_OUT);
	assign dep_out.out_time      = out_ent_q.tstamp;
	assign dep_out.out_route     = out_ent_q.pl.route;
	assign dep_out.out_heading   = out_ent_q.pl.heading;
	assign dep_out.out_agency    = out_ent_q.pl.agency;
	assign dep_out.out_live      = out_ent_q.pl.live;
	assign dep_out.out_delay     = out_ent_q.pl.delay;
	assign dep_out.entry_present = out_present_q;
	assign dep_out.last_entry    = out_last_q;

	assign pos_m1  = pos_q - CNT_W'(1);
	assign rd_k_p1 = rd_k_q + CNT_W'(1);

	// signed distance ahead of now, compared against the unsigned threshold
	assign diff     = $signed({1'b0, t_q}) - $signed({1'b0, now_q});
	assign corr_hit = corr_en_q && (pl_q.agency == corr_agency_q) &&
		(diff > $signed({1'b0, lookahead_q}));

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q[IDX_W-1:0];
		mem_wdata = rdata_q;
		mem_raddr = rd_k_q[IDX_W-1:0];
		unique case (state_q)
			S_INS_RD: begin
				mem_raddr = pos_m1[IDX_W-1:0];
				if (pos_q == '0) begin
					mem_we    = 1'b1;
					mem_wdata = '{tstamp: t_q, pl: pl_q};
				end
			end
			S_INS_CMP: begin
				if (pos_q != FULL) begin
					mem_we = 1'b1;
					if (rdata_q.tstamp > t_q)
						mem_wdata = rdata_q;
					else
						mem_wdata = '{tstamp: t_q, pl: pl_q};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[mem_waddr] <= mem_wdata;
		rdata_q <= mem_q[mem_raddr];
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					priority if (dep_in.op == OP_INSERT && dep_in.usable)
						state_d = S_CORR;
					else if (dep_in.op == OP_READ)
						state_d = (fill_q == '0) ? S_OUT : S_RD_ADDR;
					else
						state_d = S_IDLE;
				end
			end
			S_CORR:    state_d = S_INS_RD;
			S_INS_RD:  state_d = (pos_q == '0) ? S_IDLE : S_INS_CMP;
			S_INS_CMP: state_d = (rdata_q.tstamp > t_q) ? S_INS_RD : S_IDLE;
			S_RD_ADDR: state_d = S_RD_DATA;
			S_RD_DATA: state_d = S_OUT;
			S_OUT: begin
				if (out_xfer)
					state_d = out_last_q ? S_IDLE : S_RD_ADDR;
			end
			default:   state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			fill_q        <= '0;
			pos_q         <= '0;
			rd_k_q        <= '0;
			out_present_q <= 1'b0;
			out_last_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: begin
					rd_k_q <= '0;
					if (in_xfer && dep_in.op == OP_CLEAR)
						fill_q <= '0;
					if (in_xfer && dep_in.op == OP_READ && fill_q == '0) begin
						out_present_q <= 1'b0;
						out_last_q    <= 1'b1;
					end
				end
				S_CORR: begin
					// a full list opens its hole past the end: the tail falls off
					pos_q <= fill_q;
				end
				S_INS_RD: begin
					if (pos_q == '0 && fill_q != FULL)
						fill_q <= fill_q + CNT_W'(1);
				end
				S_INS_CMP: begin
					if (rdata_q.tstamp > t_q)
						pos_q <= pos_m1;
					else if (pos_q != FULL && fill_q != FULL)
						fill_q <= fill_q + CNT_W'(1);
				end
				S_RD_DATA: begin
					out_present_q <= 1'b1;
					out_last_q    <= (rd_k_p1 == fill_q);
				end
				S_OUT: begin
					if (out_xfer)
						rd_k_q <= rd_k_p1;
				end
				default: begin
				end
			endcase
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_xfer) begin
			t_q            <= dep_in.dep_time;
			now_q          <= dep_in.now_time;
			pl_q.route     <= dep_in.route_ref;
			pl_q.heading   <= dep_in.heading;
			pl_q.agency    <= dep_in.agency_code;
			pl_q.live      <= dep_in.live_flag;
			pl_q.delay     <= dep_in.delay_secs;
			out_ent_q      <= '0;
		end
		if (state_q == S_CORR && corr_hit)
			t_q <= t_q - week_shift_q;
		if (state_q == S_RD_DATA)
			out_ent_q <= rdata_q;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corr_en_q     <= RST_CORR_EN;
			corr_agency_q <= RST_CORR_AGENCY;
			lookahead_q   <= RST_LOOKAHEAD;
			week_shift_q  <= RST_WEEK_SHIFT;
		end else if (cfg_xfer) begin
			unique case (cfg.index)
				CFG_CORR_EN:     corr_en_q     <= cfg.data[0];
				CFG_CORR_AGENCY: corr_agency_q <= cfg.data[7:0];
				CFG_LOOKAHEAD:   lookahead_q   <= cfg.data;
				CFG_WEEK_SHIFT:  week_shift_q  <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL)
		else $error("fill count beyond list size");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && dep_in.op == OP_CLEAR) |=> (fill_q == '0))
		else $error("clear did not empty the list");

	a_fill_drop_only_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q < $past(fill_q)) |-> $past(in_xfer && dep_in.op == OP_CLEAR))
		else $error("fill count fell without a clear");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q > $past(fill_q)) |-> (fill_q == $past(fill_q) + CNT_W'(1)))
		else $error("fill count grew by more than one");

endmodule
